/* hdl/twsm_pkg.sv */
// ----------------------------------------------------------------------------
// twsm_pkg: shared types and constants for the window slot mapper
// Token record passed along the slot cell chain, commit command and codes.
// ----------------------------------------------------------------------------
package twsm_pkg;

	localparam int SLOTS_DEF     = 10;
	localparam int PHYS_BITS_DEF = 52;

	// slot index width covers tables of up to 64 slots
	localparam int IDX_W      = 6;
	localparam int PAGE_SHIFT = 21;
	localparam int ADDR_W     = 64;

	// base of the topmost 2 MiB page
	localparam logic [ADDR_W-1:0] WIN_TOP = ~(ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1));

	localparam logic OP_MAP   = 1'b0;
	localparam logic OP_UNMAP = 1'b1;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// request record walking down the chain
	typedef struct packed {
		logic             vld;
		logic             op;
		logic             found;     // map: frame hit; unmap: base hit
		logic             free_ok;   // map: a free slot was seen
		logic [IDX_W-1:0] match_idx;
		logic [IDX_W-1:0] free_idx;
	} tok_t;

	// slot update broadcast at the end of a request
	typedef struct packed {
		logic             en;
		logic             set;
		logic [IDX_W-1:0] idx;
	} cmd_t;

endpackage

/* hdl/temp_window_slot_mapper_top.sv */
// ----------------------------------------------------------------------------
// temp_window_slot_mapper_top: 2 MiB window slot mapper
// Maps physical addresses into a table of window slots at the top of the
// virtual address space and unmaps window bases, using a chain of slot cells.
// ----------------------------------------------------------------------------
//
//  channel   | handshake        | beat fields
//  ----------+------------------+------------------------------------------
//  request   | start / busy     | op, phys_addr, virt_addr
//  result    | done (strobe)    | window_addr, slot, status
//
// A request beat is taken when start is high and busy is low. It then walks
// the chain of SLOTS slot cells, one cell per cycle, each cell checking its
// own slot. The table is updated and the result is registered at the edge
// where the record leaves the last cell, and done is raised by that edge.
// busy stays high from the accepting edge until that same edge, so the block
// takes no new request until the current one has left the chain.
// Reset clears every slot (valid and frame) at once; no sweep is needed.
// The result is shown on done for a single cycle and cannot be held off.
// ----------------------------------------------------------------------------
module temp_window_slot_mapper_top #(
	parameter int SLOTS     = twsm_pkg::SLOTS_DEF,
	parameter int PHYS_BITS = twsm_pkg::PHYS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [51:0] phys_addr,
	input  logic [63:0] virt_addr,
	output logic        done,
	output logic [63:0] window_addr,
	output logic [3:0]  slot,
	output logic [1:0]  status
);
	import twsm_pkg::*;

	localparam int FW = PHYS_BITS - PAGE_SHIFT;
	// keep only the implemented physical address bits
	localparam logic [ADDR_W-1:0] PMASK = {ADDR_W{1'b1}} >> (ADDR_W - PHYS_BITS);
	// window base of slot zero
	localparam logic [ADDR_W-1:0] WBASE = WIN_TOP - (ADDR_W'(SLOTS - 1) << PAGE_SHIFT);

	tok_t              tok_c  [0:SLOTS];
	logic [ADDR_W-1:0] addr_c [0:SLOTS];
	logic [SLOTS-1:0]  chain_vld;

	tok_t              tok_head;
	logic [ADDR_W-1:0] addr_head;

	cmd_t              wr;
	logic [FW-1:0]     wr_frame;

	logic              busy_q;
	logic              accept;
	logic              done_q;
	logic [63:0]       waddr_q;
	logic [3:0]        slot_q;
	logic [1:0]        status_q;

	logic [63:0]       waddr_d;
	logic [IDX_W-1:0]  sel_idx;
	logic [1:0]        status_d;
	tok_t              tail;
	logic [ADDR_W-1:0] tail_addr;

	assign accept = start && !busy_q;

	// Head of the chain: build a fresh record from the request beat.
	always_comb begin
		tok_head     = '0;
		tok_head.vld = accept;
		tok_head.op  = op;
		if (op == OP_MAP) begin
			addr_head = ADDR_W'(phys_addr) & PMASK;
		end else begin
			addr_head = virt_addr;
		end
	end

	assign tok_c[0]  = tok_head;
	assign addr_c[0] = addr_head;

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		twsm_cell #(
			.SLOTS     (SLOTS),
			.PHYS_BITS (PHYS_BITS),
			.IDX       (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok_c[k]),
			.addr_in  (addr_c[k]),
			.tok_out  (tok_c[k+1]),
			.addr_out (addr_c[k+1]),
			.wr       (wr),
			.wr_frame (wr_frame)
		);
		assign chain_vld[k] = tok_c[k+1].vld;
	end

	assign tail      = tok_c[SLOTS];
	assign tail_addr = addr_c[SLOTS];

	// Tail of the chain: pick the slot, commit the table update, form result.
	always_comb begin
		wr       = '0;
		wr_frame = '0;
		sel_idx  = '0;
		status_d = ST_DONE;
		waddr_d  = '0;
		if (tail.op == OP_MAP) begin
			if (tail.found) begin
				sel_idx = tail.match_idx;
			end else if (tail.free_ok) begin
				// claim the lowest free slot
				sel_idx  = tail.free_idx;
				wr.en    = tail.vld;
				wr.set   = 1'b1;
				wr.idx   = tail.free_idx;
				wr_frame = tail_addr[PAGE_SHIFT +: FW];
			end else begin
				status_d = ST_FULL;
			end
			if (tail.found || tail.free_ok) begin
				waddr_d = (WBASE + (ADDR_W'(sel_idx) << PAGE_SHIFT))
					| {{(ADDR_W-PAGE_SHIFT){1'b0}}, tail_addr[PAGE_SHIFT-1:0]};
			end
		end else begin
			if (tail.found) begin
				// drop the slot; frame returns to zero
				sel_idx = tail.match_idx;
				wr.en   = tail.vld;
				wr.set  = 1'b0;
				wr.idx  = tail.match_idx;
			end else begin
				status_d = ST_NOT_FOUND;
			end
		end
	end

	// Hold busy from accept until the record leaves the last cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.vld) begin
				busy_q <= 1'b0;
			end
			done_q <= tail.vld;
		end
	end

	// Result register: advance only when a record completes.
	always_ff @(posedge clk) begin
		if (tail.vld) begin
			waddr_q  <= waddr_d;
			slot_q   <= sel_idx[3:0];
			status_q <= status_d;
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign window_addr = waddr_q;
	assign slot        = slot_q;
	assign status      = status_q;

	// At most one request in the chain at any time.
	a_one_in_flight : assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld))
		else $error("more than one request in the cell chain");

	// An accepted request keeps the block busy in the next cycle.
	a_busy_after_accept : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accept");

	// The result strobe comes while idle and lasts one cycle.
	a_done_idle : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is in flight");

	a_done_single : assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A failed request never reports a window address or slot.
	a_fail_clean : assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_DONE |-> window_addr == 64'd0 && slot == 4'd0)
		else $error("failed request reports an address or slot");

endmodule

/* hdl/twsm_cell.sv */
// ----------------------------------------------------------------------------
// twsm_cell: one window slot of the mapper chain
// Holds a slot's valid bit and frame, checks the passing request, forwards it.
// ----------------------------------------------------------------------------
module twsm_cell #(
	parameter int SLOTS     = twsm_pkg::SLOTS_DEF,
	parameter int PHYS_BITS = twsm_pkg::PHYS_BITS_DEF,
	parameter int IDX       = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  twsm_pkg::tok_t                       tok_in,
	input  logic [twsm_pkg::ADDR_W-1:0]          addr_in,
	output twsm_pkg::tok_t                       tok_out,
	output logic [twsm_pkg::ADDR_W-1:0]          addr_out,
	input  twsm_pkg::cmd_t                       wr,
	input  logic [PHYS_BITS-twsm_pkg::PAGE_SHIFT-1:0] wr_frame
);
	import twsm_pkg::*;

	localparam int FW = PHYS_BITS - PAGE_SHIFT;
	localparam logic [ADDR_W-1:0] BASE =
		WIN_TOP - (ADDR_W'(SLOTS - 1 - IDX) << PAGE_SHIFT);

	logic          valid_q;
	logic [FW-1:0] frame_q;
	tok_t          tok_q;
	tok_t          tok_d;
	logic [ADDR_W-1:0] addr_q;

	always_comb begin
		tok_d = tok_in;
		if (tok_in.op == OP_MAP) begin
			if (!tok_in.found && valid_q && frame_q == addr_in[PAGE_SHIFT +: FW]) begin
				tok_d.found     = 1'b1;
				tok_d.match_idx = IDX_W'(IDX);
			end
			if (!tok_in.free_ok && !valid_q) begin
				tok_d.free_ok  = 1'b1;
				tok_d.free_idx = IDX_W'(IDX);
			end
		end else begin
			if (!tok_in.found && addr_in == BASE) begin
				tok_d.found     = 1'b1;
				tok_d.match_idx = IDX_W'(IDX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			valid_q <= 1'b0;
			frame_q <= '0;
		end else begin
			tok_q <= tok_d;
			if (wr.en && wr.idx == IDX_W'(IDX)) begin
				valid_q <= wr.set;
				frame_q <= wr_frame;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_in;
	end

	assign tok_out  = tok_q;
	assign addr_out = addr_q;

endmodule

/* sim/temp_window_slot_mapper_check.sv */
// ----------------------------------------------------------------------------
// temp_window_slot_mapper_check: result predictor and comparator
// Watches the request and result channels of the window slot mapper, keeps
// its own copy of the slot table, and compares every result beat with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module temp_window_slot_mapper_check #(
	parameter int SLOTS     = twsm_pkg::SLOTS_DEF,
	parameter int PHYS_BITS = twsm_pkg::PHYS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        op,
	input  logic [51:0] phys_addr,
	input  logic [63:0] virt_addr,
	input  logic        done,
	input  logic [63:0] window_addr,
	input  logic [3:0]  slot,
	input  logic [1:0]  status,
	output int          pending,
	output int          errors,
	output int          n_fill,
	output int          n_reuse,
	output int          n_full,
	output int          n_unmap,
	output int          n_miss
);
	timeunit 1ns;
	timeprecision 1ps;
	import twsm_pkg::*;

	localparam logic [63:0] PAGE = 64'd1 << PAGE_SHIFT;
	localparam logic [51:0] PA_MASK =
		(PHYS_BITS >= 52) ? {52{1'b1}} : ((52'd1 << PHYS_BITS) - 52'd1);

	typedef struct packed {
		logic [63:0] waddr;
		logic [3:0]  idx;
		logic [1:0]  st;
	} mapping_t;

	logic        slot_used  [SLOTS];
	logic [30:0] slot_frame [SLOTS];
	mapping_t    expected_mappings[$];

	function automatic logic [63:0] window_base(int i);
		return WIN_TOP - 64'(SLOTS - 1) * PAGE + 64'(i) * PAGE;
	endfunction

	// apply one request to the shadow table and return the mapping it yields
	function automatic mapping_t resolve_request(logic o, logic [51:0] pa_in,
	                                             logic [63:0] va);
		mapping_t    r;
		logic [51:0] pa;
		logic [30:0] frame;
		logic        hit;
		int          idx;
		pa    = pa_in & PA_MASK;
		frame = pa[51:PAGE_SHIFT];
		hit   = 1'b0;
		idx   = 0;
		r     = '0;
		if (o == OP_MAP) begin
			for (int i = 0; i < SLOTS; i++)
				if (!hit && slot_used[i] && slot_frame[i] == frame) begin
					hit = 1'b1;
					idx = i;
				end
			if (hit)
				n_reuse++;
			for (int i = 0; i < SLOTS; i++)
				if (!hit && !slot_used[i]) begin
					hit           = 1'b1;
					idx           = i;
					slot_used[i]  = 1'b1;
					slot_frame[i] = frame;
					n_fill++;
				end
			if (hit) begin
				r.waddr = window_base(idx) | 64'(pa[PAGE_SHIFT-1:0]);
				r.idx   = 4'(idx);
				r.st    = ST_DONE;
			end else begin
				r.st = ST_FULL;
				n_full++;
			end
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (!hit && window_base(i) == va) begin
					hit           = 1'b1;
					idx           = i;
					slot_used[i]  = 1'b0;
					slot_frame[i] = '0;
				end
			if (hit) begin
				r.idx = 4'(idx);
				r.st  = ST_DONE;
				n_unmap++;
			end else begin
				r.st = ST_NOT_FOUND;
				n_miss++;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mapping_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_used[i]  = 1'b0;
				slot_frame[i] = '0;
			end
			expected_mappings.delete();
			pending <= 0;
			errors  = 0;
			n_fill  = 0;
			n_reuse = 0;
			n_full  = 0;
			n_unmap = 0;
			n_miss  = 0;
		end else begin
			if (done) begin
				if (expected_mappings.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%t: unexpected result addr=%h slot=%0d status=%0d",
						         $realtime, window_addr, slot, status);
				end else begin
					want = expected_mappings.pop_front();
					if (window_addr !== want.waddr || slot !== want.idx ||
					    status !== want.st) begin
						errors++;
						if (errors <= 10) begin
							$display("%t: mismatch expected addr=%h slot=%0d status=%0d",
							         $realtime, want.waddr, want.idx, want.st);
							$display("    got addr=%h slot=%0d status=%0d",
							         window_addr, slot, status);
						end
					end
				end
			end
			if (start && !busy)
				expected_mappings.push_back(resolve_request(op, phys_addr, virt_addr));
			pending <= expected_mappings.size();
		end
	end

endmodule

/* sim/temp_window_slot_mapper_top_test.sv */
// ----------------------------------------------------------------------------
// temp_window_slot_mapper_top_test: testbench for the window slot mapper
// Drives map and unmap requests (a directed opening, then random phases that
// fill, share, overflow and free the slot table) and lets a checker module
// predict and compare every result; prints the verdict at the end.
// ----------------------------------------------------------------------------
module temp_window_slot_mapper_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import twsm_pkg::*;

	localparam int          NSLOTS     = SLOTS_DEF;
	localparam int          NUM_RANDOM = 1680;
	localparam logic [63:0] PAGE       = 64'd1 << PAGE_SHIFT;

	// all inputs start at known values
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        op        = OP_MAP;
	logic [51:0] phys_addr = '0;
	logic [63:0] virt_addr = '0;

	logic        busy;
	logic        done;
	logic [63:0] window_addr;
	logic [3:0]  slot;
	logic [1:0]  status;

	int pending, errors, n_fill, n_reuse, n_full, n_unmap, n_miss;
	int beats = 0;

	// small set of frames so that maps share slots and the table overflows
	logic [30:0] frame_pool [16];

	temp_window_slot_mapper_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.phys_addr   (phys_addr),
		.virt_addr   (virt_addr),
		.done        (done),
		.window_addr (window_addr),
		.slot        (slot),
		.status      (status)
	);

	temp_window_slot_mapper_check CHK (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.phys_addr   (phys_addr),
		.virt_addr   (virt_addr),
		.done        (done),
		.window_addr (window_addr),
		.slot        (slot),
		.status      (status),
		.pending     (pending),
		.errors      (errors),
		.n_fill      (n_fill),
		.n_reuse     (n_reuse),
		.n_full      (n_full),
		.n_unmap     (n_unmap),
		.n_miss      (n_miss)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [63:0] window_base(int i);
		return WIN_TOP - 64'(NSLOTS - 1) * PAGE + 64'(i) * PAGE;
	endfunction

	// Present one request beat and hold it until the edge that takes it.
	// start stays high on return, so a following call keeps the channel full
	// without dropping start in between.
	task automatic issue(input logic o, input logic [51:0] pa, input logic [63:0] va);
		start     <= 1'b1;
		op        <= o;
		phys_addr <= pa;
		virt_addr <= va;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		beats++;
	endtask

	// drop start for a burst of idle cycles
	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off the sender until every predicted result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// One random beat. Most maps draw their frame from the pool and most
	// unmaps hit an exact window base; other maps take a random frame and other unmaps use a non-base or random address.
	task automatic random_request(input int map_pct);
		logic [51:0] pa;
		logic [63:0] va;
		logic [20:0] off;
		int          k;
		pa  = 52'({$urandom, $urandom});
		va  = {$urandom, $urandom};
		off = 21'($urandom);
		if (off == '0)
			off = 21'd1;
		if ($urandom_range(99) < map_pct) begin
			if ($urandom_range(99) < 85)
				pa = {frame_pool[$urandom_range(15)], pa[PAGE_SHIFT-1:0]};
			issue(OP_MAP, pa, va);
		end else begin
			k = $urandom_range(99);
			if (k < 70)
				va = window_base($urandom_range(NSLOTS - 1));
			else if (k < 80)
				va = window_base($urandom_range(NSLOTS - 1)) | 64'(off);
			else if (k < 85)
				va = window_base(0) - PAGE;
			else if (k < 88)
				va = '1;
			else if (k < 91)
				va = '0;
			issue(OP_UNMAP, pa, va);
		end
	endtask

	initial begin : stimulus
		int map_pct;
		bit quiet;
		map_pct = 55;
		quiet   = 1'b0;
		frame_pool[0] = '0;
		frame_pool[1] = '1;
		for (int i = 2; i < 16; i++)
			frame_pool[i] = 31'($urandom);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed opening ---
		// frame zero is a real frame; then the top frame with every offset bit set
		issue(OP_MAP, 52'd0, '1);
		issue(OP_MAP, '1, '0);
		// same frame zero, other offset: reuse slot 0
		issue(OP_MAP, 52'h1F_FFFF, '0);
		// exact base unmaps, the second one on a slot already free
		issue(OP_UNMAP, '0, window_base(0));
		issue(OP_UNMAP, '0, window_base(0));
		// base plus offset, zero, all ones and the page below the window: all miss
		issue(OP_UNMAP, '1, window_base(1) | 64'd1);
		issue(OP_UNMAP, '0, 64'd0);
		issue(OP_UNMAP, '0, '1);
		issue(OP_UNMAP, '0, window_base(0) - PAGE);
		// topmost slot, still free
		issue(OP_UNMAP, '0, window_base(NSLOTS - 1));
		// fill every free slot with new frames; the last one finds the table full
		for (int i = 0; i < NSLOTS; i++)
			issue(OP_MAP, {31'(i + 2), 21'(i * 977)}, '0);
		// a full table still hands out a slot that already holds the frame
		issue(OP_MAP, {31'h7FFF_FFFF, 21'h0}, '0);
		issue(OP_UNMAP, '0, window_base(1));

		drain();

		// --- random phases ---
		for (int n = 0; n < NUM_RANDOM; n++) begin
			// every hundred beats pick a new map/unmap mix and idling mode
			if (n % 100 == 0) begin
				case ($urandom_range(2))
					0: map_pct = 30;
					1: map_pct = 55;
					default: map_pct = 80;
				endcase
				quiet = ($urandom_range(2) == 0);
			end
			if (n == NUM_RANDOM / 2)
				drain();
			// advance the frame pool now and then so new frames keep arriving
			if ($urandom_range(49) == 0)
				frame_pool[$urandom_range(15)] = 31'($urandom);
			random_request(map_pct);
			// no idling in the last part of the run
			if (!quiet && n < NUM_RANDOM * 85 / 100 && $urandom_range(3) == 0)
				pause($urandom_range(1, 7));
		end

		// --- wind down ---
		drain();
		repeat (2 * NSLOTS + 4) @(posedge clk);

		$display("run covered %0d request beats: %0d new slots, %0d shared frames, %0d table full",
		         beats, n_fill, n_reuse, n_full);
		$display("and %0d unmaps that cleared a slot, %0d that found none",
		         n_unmap, n_miss);
		if (errors == 0)
			$display("[temp_window_slot_mapper_top] OK");
		else
			$display("[temp_window_slot_mapper_top] ERROR");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("[temp_window_slot_mapper_top] ERROR");
		$finish;
	end

endmodule

/* sim.f */
hdl/twsm_pkg.sv
hdl/twsm_cell.sv
hdl/temp_window_slot_mapper_top.sv
sim/temp_window_slot_mapper_check.sv
sim/temp_window_slot_mapper_top_test.sv
